### hw/rtl/bsms_pkg.sv
// Shared package for the binary-split multinomial sampler.
// Holds default parameter values and the command and status types between
// the controller and the datapath. No dependencies.
package bsms_pkg;

    localparam int NumBits = 32;
    localparam int BitIdxW = 5;

    localparam int DefNumVariants   = 16;
    localparam int DefNumCategories = 8;
    localparam int DefCountBits     = 32;

    typedef struct packed {
        logic               load_wr;
        logic               start;
        logic               scan;
        logic [BitIdxW-1:0] bit_idx;
        logic               emit;
    } t_dp_cmd;

    typedef struct packed {
        logic out_ready;
        logic emit_last;
    } t_dp_status;

endpackage

### hw/rtl/bsms_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bsms_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/bsms_ctrl.sv
// Controller state machine of the sampler: accepts items, sequences the bit
// scan and the result transfers. Depends on bsms_pkg.
module bsms_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  logic                  i_action,
    input  bsms_pkg::t_dp_status  i_status,
    output logic                  o_stall,
    output bsms_pkg::t_dp_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    localparam logic [bsms_pkg::BitIdxW-1:0] LastBit =
        bsms_pkg::BitIdxW'(bsms_pkg::NumBits - 1);

    t_state                        r_state;
    logic [bsms_pkg::BitIdxW-1:0]  r_bit_idx;
    logic                          w_idle;

    assign w_idle  = (r_state == ST_IDLE);
    assign o_stall = !w_idle;

    always_comb begin
        o_cmd         = '0;
        o_cmd.load_wr = w_idle && i_valid && !i_action;
        o_cmd.start   = w_idle && i_valid && i_action;
        o_cmd.scan    = (r_state == ST_SCAN);
        o_cmd.bit_idx = r_bit_idx;
        o_cmd.emit    = (r_state == ST_EMIT) && i_status.out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_bit_idx <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_bit_idx <= '0;
                    if (i_valid && i_action) begin
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_bit_idx <= r_bit_idx + 1'b1;
                    if (r_bit_idx == LastBit) begin
                        r_state <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (i_status.out_ready && i_status.emit_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_sample_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) && i_valid && i_action |=>
            (r_state == ST_SCAN) && (r_bit_idx == '0))
        else $error("sample transfer did not start the bit scan at bit zero");

    a_scan_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) && (r_bit_idx == LastBit) |=> (r_state == ST_DRAIN))
        else $error("bit scan did not end after the last bit");

    a_emit_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) && i_status.out_ready && i_status.emit_last |=>
            (r_state == ST_IDLE))
        else $error("controller did not return to idle after the last result");

endmodule

### hw/rtl/bsms_datapath.sv
// Datapath of the sampler: draw table lanes, variant pointers, per-category
// sums and the output register. Depends on bsms_pkg and bsms_ram.
module bsms_datapath #(
    parameter int NUM_VARIANTS   = bsms_pkg::DefNumVariants,
    parameter int NUM_CATEGORIES = bsms_pkg::DefNumCategories,
    parameter int COUNT_BITS     = bsms_pkg::DefCountBits
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bsms_pkg::t_dp_cmd     i_cmd,
    output bsms_pkg::t_dp_status  o_status,
    input  logic [4:0]            i_bit_position,
    input  logic [3:0]            i_variant_slot,
    input  logic [2:0]            i_category,
    input  logic [31:0]           i_entry_value,
    input  logic [31:0]           i_trial_count,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_category_out,
    output logic [31:0]           o_count,
    output logic                  o_last
);

    localparam int VptrW = (NUM_VARIANTS > 1) ? $clog2(NUM_VARIANTS) : 1;
    localparam int CatW  = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
    localparam int AddrW = bsms_pkg::BitIdxW + VptrW;
    localparam int Depth = 1 << AddrW;

    logic [31:0]            r_trial;
    logic [VptrW-1:0]       r_vptr [bsms_pkg::NumBits];
    logic                   r_acc_en;
    logic [CatW-1:0]        r_emit_idx;
    logic                   r_out_valid;
    logic [2:0]             r_out_cat;
    logic [31:0]            r_out_count;
    logic                   r_out_last;
    logic [COUNT_BITS-1:0]  r_sum [NUM_CATEGORIES];

    logic                   w_rd_en;
    logic [VptrW-1:0]       w_cur_vptr;
    logic [VptrW-1:0]       n_vptr;
    logic [AddrW-1:0]       w_rd_addr;
    logic [AddrW-1:0]       w_wr_addr;
    logic                   w_slot_ok;
    logic                   w_emit_last;

    assign w_cur_vptr = r_vptr[i_cmd.bit_idx];
    assign w_rd_en    = i_cmd.scan && r_trial[i_cmd.bit_idx];
    assign w_rd_addr  = {i_cmd.bit_idx, w_cur_vptr};
    assign n_vptr     = (w_cur_vptr == VptrW'(NUM_VARIANTS - 1)) ? '0 : w_cur_vptr + 1'b1;
    assign w_wr_addr  = {i_bit_position, VptrW'(i_variant_slot)};
    assign w_slot_ok  = (int'(i_variant_slot) < NUM_VARIANTS);
    assign w_emit_last = (r_emit_idx == CatW'(NUM_CATEGORIES - 1));

    assign o_status.out_ready = !r_out_valid || !i_stall;
    assign o_status.emit_last = w_emit_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_trial <= i_trial_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < bsms_pkg::NumBits; b++) begin
                r_vptr[b] <= '0;
            end
            r_acc_en    <= 1'b0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_rd_en) begin
                r_vptr[i_cmd.bit_idx] <= n_vptr;
            end
            r_acc_en <= w_rd_en;
            if (i_cmd.start) begin
                r_emit_idx <= '0;
            end else if (i_cmd.emit) begin
                r_emit_idx <= r_emit_idx + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_cat   <= 3'(r_emit_idx);
            r_out_count <= 32'(r_sum[0]);
            r_out_last  <= w_emit_last;
        end
    end

    for (genvar c = 0; c < NUM_CATEGORIES; c++) begin : g_lane
        logic                  w_wr_en;
        logic [COUNT_BITS-1:0] w_rd_data;

        assign w_wr_en = i_cmd.load_wr && w_slot_ok && (int'(i_category) == c);

        bsms_ram #(
            .WIDTH (COUNT_BITS),
            .DEPTH (Depth)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (w_wr_en),
            .i_wr_addr (w_wr_addr),
            .i_wr_data (COUNT_BITS'(i_entry_value)),
            .i_rd_en   (w_rd_en),
            .i_rd_addr (w_rd_addr),
            .o_rd_data (w_rd_data)
        );

        always_ff @(posedge i_clk) begin
            if (i_cmd.start) begin
                r_sum[c] <= '0;
            end else if (r_acc_en) begin
                r_sum[c] <= r_sum[c] + w_rd_data;
            end else if (i_cmd.emit) begin
                if (c == NUM_CATEGORIES - 1) begin
                    r_sum[c] <= '0;
                end else begin
                    r_sum[c] <= r_sum[(c + 1) % NUM_CATEGORIES];
                end
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_category_out = r_out_cat;
    assign o_count        = r_out_count;
    assign o_last         = r_out_last;

    a_acc_follows_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc_en |-> $past(i_cmd.scan))
        else $error("accumulation without a table read in the previous cycle");

    a_emit_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> o_valid)
        else $error("result load did not fill the output register");

    a_last_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit && w_emit_last |=> o_valid && o_last)
        else $error("final category of a sample not marked as last");

endmodule

### hw/rtl/binary_split_multinomial_sampler.sv
// Top level of the binary-split multinomial sampler.
// Joins bsms_ctrl and bsms_datapath; depends on bsms_pkg.
//
// Input channel (i_valid / o_stall): a transfer with i_action low writes one
// draw table entry and completes in the cycle it is taken; loads may follow
// each other in every cycle. A transfer with i_action high starts a sample of
// i_trial_count trials. The block then scans all 32 bit positions, one per
// cycle, reading the selected table row of every set bit (one row read per
// cycle, all categories in parallel), and holds o_stall high until the
// results have been handed to the output register.
// Output channel (o_valid / i_stall): one transfer per category, in category
// order, o_last on the final one. After the bit scan and a drain state, the
// emit state loads the results into the output register in turn. The output
// register holds a stalled result and the sequencer waits; the last result
// may still be pending while the next item is taken.
// Reset clears the variant pointers and the control state. The draw table is
// not cleared and must be loaded before it is sampled.
module binary_split_multinomial_sampler #(
    parameter int NUM_VARIANTS   = bsms_pkg::DefNumVariants,
    parameter int NUM_CATEGORIES = bsms_pkg::DefNumCategories,
    parameter int COUNT_BITS     = bsms_pkg::DefCountBits
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [4:0]  i_bit_position,
    input  logic [3:0]  i_variant_slot,
    input  logic [2:0]  i_category,
    input  logic [31:0] i_entry_value,
    input  logic [31:0] i_trial_count,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_category_out,
    output logic [31:0] o_count,
    output logic        o_last
);

    bsms_pkg::t_dp_cmd    w_cmd;
    bsms_pkg::t_dp_status w_status;

    bsms_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_status (w_status),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd)
    );

    bsms_datapath #(
        .NUM_VARIANTS   (NUM_VARIANTS),
        .NUM_CATEGORIES (NUM_CATEGORIES),
        .COUNT_BITS     (COUNT_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .i_bit_position (i_bit_position),
        .i_variant_slot (i_variant_slot),
        .i_category     (i_category),
        .i_entry_value  (i_entry_value),
        .i_trial_count  (i_trial_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_category_out (o_category_out),
        .o_count        (o_count),
        .o_last         (o_last)
    );

endmodule

### tb/tb_top.sv
// Self-checking testbench for binary_split_multinomial_sampler: loads the draw table,
// runs directed and random loads and samples, and checks every category count.
// Depends on bsms_pkg and the sampler RTL.
module tb_top;

    localparam int NumBits       = bsms_pkg::NumBits;
    localparam int NumVariants   = bsms_pkg::DefNumVariants;
    localparam int NumCategories = bsms_pkg::DefNumCategories;
    localparam bit ActLoad       = 1'b0;
    localparam bit ActSample     = 1'b1;
    localparam int IdlePct       = 16;

    typedef struct {
        bit [2:0]  category;
        bit [31:0] count;
        bit        last;
    } t_sample_count;

    class t_split_sum_tracker;
        bit [31:0]     draw_mem [NumBits][NumVariants][NumCategories];
        bit            written [NumBits][NumVariants][NumCategories];
        bit [3:0]      variant_ptr [NumBits];
        t_sample_count expected_counts [$];
        int            error_count;

        task report_error(string msg);
            $display("mismatch: %s", msg);
            error_count++;
        endtask

        function bit [31:0] ready_mask();
            bit [31:0] mask;
            mask = '0;
            for (int b = 0; b < NumBits; b++) begin
                mask[b] = 1'b1;
                for (int c = 0; c < NumCategories; c++) begin
                    if (!written[b][variant_ptr[b]][c]) begin
                        mask[b] = 1'b0;
                    end
                end
            end
            return mask;
        endfunction

        function void take_item(bit act, bit [4:0] bpos, bit [3:0] slot, bit [2:0] cat,
                                bit [31:0] val, bit [31:0] trials);
            bit [31:0]     sums [NumCategories];
            t_sample_count r;
            if (act == ActLoad) begin
                if (slot < NumVariants && cat < NumCategories) begin
                    draw_mem[bpos][slot][cat] = val;
                    written[bpos][slot][cat]  = 1'b1;
                end
                return;
            end
            foreach (sums[c]) sums[c] = '0;
            for (int b = 0; b < NumBits; b++) begin
                if (trials[b]) begin
                    for (int c = 0; c < NumCategories; c++) begin
                        sums[c] += draw_mem[b][variant_ptr[b]][c];
                    end
                    variant_ptr[b] = 4'((variant_ptr[b] + 1) % NumVariants);
                end
            end
            for (int c = 0; c < NumCategories; c++) begin
                r.category = 3'(c);
                r.count    = sums[c];
                r.last     = (c == NumCategories - 1);
                expected_counts.push_back(r);
            end
        endfunction

        task check_count(bit [2:0] cat, bit [31:0] cnt, bit last);
            t_sample_count e;
            if (expected_counts.size() == 0) begin
                report_error($sformatf("unexpected result category %0d count %h", cat, cnt));
                return;
            end
            e = expected_counts.pop_front();
            if (cat != e.category) begin
                report_error($sformatf("category %0d, expected %0d", cat, e.category));
            end
            if (cnt != e.count) begin
                report_error($sformatf("category %0d count %h, expected %h",
                                       e.category, cnt, e.count));
            end
            if (last != e.last) begin
                report_error($sformatf("category %0d last %0d, expected %0d",
                                       e.category, last, e.last));
            end
        endtask
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic        i_action       = 1'b0;
    logic [4:0]  i_bit_position = '0;
    logic [3:0]  i_variant_slot = '0;
    logic [2:0]  i_category     = '0;
    logic [31:0] i_entry_value  = '0;
    logic [31:0] i_trial_count  = '0;
    logic        i_stall        = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [2:0]  o_category_out;
    logic [31:0] o_count;
    logic        o_last;

    t_split_sum_tracker tracker = new;
    bit                 no_idle = 1'b0;
    int                 rx_hold_cycles = 0;

    binary_split_multinomial_sampler uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_action       (i_action),
        .i_bit_position (i_bit_position),
        .i_variant_slot (i_variant_slot),
        .i_category     (i_category),
        .i_entry_value  (i_entry_value),
        .i_trial_count  (i_trial_count),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_category_out (o_category_out),
        .o_count        (o_count),
        .o_last         (o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic bit [31:0] pick_entry_value();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h8000_0000;
            2: return 32'h7FFF_FFFF;
            default: return $urandom_range(0, 32'h8000_0000);
        endcase
    endfunction

    function automatic bit [31:0] pick_trial_count();
        case ($urandom_range(0, 5))
            0: return 32'h1 << $urandom_range(0, 31);
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(bit act, bit [4:0] bpos, bit [3:0] slot, bit [2:0] cat,
                             bit [31:0] val, bit [31:0] trials);
        while (!no_idle && $urandom_range(0, 99) < IdlePct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_action       <= act;
        i_bit_position <= bpos;
        i_variant_slot <= slot;
        i_category     <= cat;
        i_entry_value  <= val;
        i_trial_count  <= trials;
        do @(posedge i_clk); while (o_stall);
        tracker.take_item(act, bpos, slot, cat, val, trials);
    endtask

    task automatic send_row(bit [4:0] bpos, bit [3:0] slot);
        for (int c = 0; c < NumCategories; c++) begin
            send_item(ActLoad, bpos, slot, 3'(c), pick_entry_value(), $urandom);
        end
    endtask

    // Samples only use bit positions whose next row has been written.
    task automatic send_random_items(int num_items, int sample_pct);
        int k = 0;
        int b;
        while (k < num_items) begin
            if ($urandom_range(0, 99) < sample_pct) begin
                send_item(ActSample, 5'($urandom), 4'($urandom), 3'($urandom),
                          $urandom, pick_trial_count() & tracker.ready_mask());
                k++;
            end else if ($urandom_range(0, 2) == 0) begin
                send_item(ActLoad, 5'($urandom), 4'($urandom), 3'($urandom),
                          pick_entry_value(), $urandom);
                k++;
            end else begin
                b = $urandom_range(0, NumBits - 1);
                send_row(5'(b), tracker.variant_ptr[b]);
                k += NumCategories;
            end
        end
    endtask

    task automatic wait_for_drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_counts.size() != 0);
    endtask

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                tracker.check_count(o_category_out, o_count, o_last);
            end
            if (rx_hold_cycles > 0) begin
                i_stall <= 1'b1;
                rx_hold_cycles--;
            end else begin
                i_stall <= !no_idle && ($urandom_range(0, 99) < IdlePct);
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Row zero of every bit position is written before the first sample reads it.
        for (int b = 0; b < NumBits; b++) begin
            for (int c = 0; c < NumCategories; c++) begin
                send_item(ActLoad, 5'(b), 4'd0, 3'(c), pick_entry_value(), $urandom);
            end
        end

        send_item(ActSample, 5'd31, 4'd15, 3'd7, 32'hFFFF_FFFF, 32'h0);
        send_item(ActSample, 5'($urandom), 4'($urandom), 3'($urandom), $urandom,
                  32'hFFFF_FFFF);
        send_item(ActLoad, 5'd31, 4'd15, 3'd7, 32'h8000_0000, 32'hFFFF_FFFF);
        send_item(ActLoad, 5'd0, 4'd0, 3'd0, 32'h0, 32'h0);

        // Two rows of 32'h8000_0000 make every sum wrap to zero.
        for (int b = 0; b < 2; b++) begin
            for (int c = 0; c < NumCategories; c++) begin
                send_item(ActLoad, 5'(b), tracker.variant_ptr[b], 3'(c), 32'h8000_0000,
                          $urandom);
            end
        end
        send_item(ActSample, 5'($urandom), 4'($urandom), 3'($urandom), $urandom, 32'h3);

        send_random_items(60, 50);
        no_idle = 1'b1;
        send_random_items(60, 50);
        no_idle = 1'b0;
        wait_for_drain();

        rx_hold_cycles = 400;
        send_random_items(50, 90);
        send_random_items(60, 50);

        wait_for_drain();
        repeat (60) @(posedge i_clk);
        if (tracker.error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #1_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

### sim.f
hw/rtl/bsms_pkg.sv
hw/rtl/bsms_ram.sv
hw/rtl/bsms_ctrl.sv
hw/rtl/bsms_datapath.sv
hw/rtl/binary_split_multinomial_sampler.sv
tb/tb_top.sv
